// File: rtl/cepp_pkg.sv
// ----------------------------------------------------------------------------
// cepp_pkg
// Shared types and codes of the coalescing event packet packer.
// ----------------------------------------------------------------------------
package cepp_pkg;

  localparam int BUF_W = 7;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_APPENDED  = 2'd0;
  localparam logic [1:0] ST_REPLACED  = 2'd1;
  localparam logic [1:0] ST_DROP_FULL = 2'd2;
  localparam logic [1:0] ST_DROP_SIZE = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] event_type;
    logic [5:0] event_size;
    logic       replace_same_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic [1:0] add_status;
  } out_item_t;

  // one queue entry: size, type and the payload buffer it owns
  typedef struct packed {
    logic [5:0]       size;
    logic [7:0]       etype;
    logic [BUF_W-1:0] buf_id;
  } cell_t;

  typedef struct packed {
    logic       pop;
    logic       remove;
    logic [7:0] key;
    logic [5:0] new_size;
    logic [7:0] new_type;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT,
    S_EMIT_CNT,
    S_SZ,
    S_TY,
    S_RD,
    S_PAY,
    S_POP,
    S_ZERO
  } state_t;

endpackage

// File: rtl/cepp_cell.sv
// ----------------------------------------------------------------------------
// cepp_cell
// One queue entry; takes its right neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module cepp_cell #(
  parameter int INIT_BUF = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cepp_pkg::cell_ctl_t ctl,
  input  logic               vld,
  input  logic               load,
  input  logic               hit_in,
  output logic               hit_out,
  output logic               first,
  input  cepp_pkg::cell_t    nbr,
  output cepp_pkg::cell_t    q
);

  cepp_pkg::cell_t q_r, q_nxt;
  logic hit;
  logic shift;

  assign hit     = vld && (q_r.etype == ctl.key);
  assign hit_out = hit_in || hit;
  assign first   = hit && !hit_in;
  // on removal every entry from the first match onward moves left
  assign shift   = ctl.pop || (ctl.remove && hit_out);

  always_comb begin
    q_nxt = q_r;
    if (shift) begin
      q_nxt = nbr;
    end
    if (load) begin
      q_nxt.size  = ctl.new_size;
      q_nxt.etype = ctl.new_type;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.size   <= '0;
      q_r.etype  <= '0;
      q_r.buf_id <= cepp_pkg::BUF_W'(INIT_BUF);
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// File: rtl/coalescing_event_packet_packer_top.sv
// ----------------------------------------------------------------------------
// coalescing_event_packet_packer_top
// Event queue with same-type replacement, packed into fixed-size packets.
// ----------------------------------------------------------------------------
// Input items: an add item carries one payload byte of an event; the item
// that completes an event returns one status item. A get item returns
// PACKET_BYTES packet byte items, count byte first, last one flagged.
// Queue entries are a row of cells, each owning one payload buffer in a
// single memory; removal shifts the cells left and rotates the freed
// buffer to the far end, so no payload is ever copied.
// Timing: an add item is handled in the cycle it is taken, also when it
// completes an event (search, removal and append). A get walks the head
// entries one per cycle to find the count, then, while the output is not
// stalled, emits one byte per cycle for size, type and zero bytes; each
// payload byte is first read from the memory (the read is registered) and
// then emitted, and each packed entry is dropped in a state of its own
// before the next one is emitted.
// No new item is taken while a packet is being built or while the output
// register is full and stalled. A stalled output item holds. Reset empties
// the queue and the partly collected event; no clearing pass is needed.
// ----------------------------------------------------------------------------
module coalescing_event_packet_packer_top #(
  parameter int PACKET_BYTES    = 64,
  parameter int QUEUE_DEPTH     = 16,
  parameter int MAX_EVENT_BYTES = 60
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cepp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cepp_pkg::out_item_t  out_item
);

  localparam int IW        = $clog2(QUEUE_DEPTH + 1);
  localparam int NCELL     = QUEUE_DEPTH + 1;
  localparam int MEM_DEPTH = NCELL * MAX_EVENT_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int BIW       = $clog2(PACKET_BYTES);

  localparam logic [AW-1:0]  MAXA  = AW'(MAX_EVENT_BYTES);
  localparam logic [5:0]     MAXS  = 6'(MAX_EVENT_BYTES);
  localparam logic [IW-1:0]  DEPTH = IW'(QUEUE_DEPTH);
  localparam logic [7:0]     PB8   = 8'(PACKET_BYTES);
  localparam logic [BIW-1:0] LASTI = BIW'(PACKET_BYTES - 1);

  cepp_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]  count_r, count_nxt;
  logic [5:0]     br_r, br_nxt;
  logic [IW-1:0]  k_r, k_nxt;
  logic [7:0]     pos_r, pos_nxt;
  logic [IW-1:0]  ev_r, ev_nxt;
  logic [5:0]     off_r, off_nxt;
  logic [BIW-1:0] bi_r, bi_nxt;

  cepp_pkg::out_item_t out_r, out_d;
  logic out_valid_r, out_load, out_free;

  logic [7:0]    mem [0:MEM_DEPTH-1];
  logic [7:0]    mem_q_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;

  cepp_pkg::cell_ctl_t ctl;
  cepp_pkg::cell_t     q    [0:NCELL-1];
  cepp_pkg::cell_t     nbr  [0:NCELL-1];
  logic [NCELL:0]      hit;
  logic [NCELL-1:0]    first, vld, load;
  logic [cepp_pkg::BUF_W-1:0] rm_buf;

  logic          in_acc, append, replaced, done, oversize;
  logic [IW-1:0] app_idx;
  logic [5:0]    br_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == cepp_pkg::S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------- cells
  assign hit[0] = 1'b0;

  genvar j;
  generate
    for (j = 0; j < NCELL; j++) begin : g_cell
      assign vld[j]  = IW'(j) < count_r;
      assign load[j] = append && (app_idx == IW'(j));
      if (j < NCELL - 1) begin : g_mid
        assign nbr[j] = q[j+1];
      end else begin : g_end
        // freed buffer wraps around to the end of the row
        assign nbr[j] = '{size: 6'd0, etype: 8'd0, buf_id: rm_buf};
      end
      cepp_cell #(.INIT_BUF(j)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .vld     (vld[j]),
        .load    (load[j]),
        .hit_in  (hit[j]),
        .hit_out (hit[j+1]),
        .first   (first[j]),
        .nbr     (nbr[j]),
        .q       (q[j])
      );
    end
  endgenerate

  always_comb begin
    rm_buf = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (first[i]) begin
        rm_buf = rm_buf | q[i].buf_id;
      end
    end
    if (ctl.pop) begin
      rm_buf = q[0].buf_id;
    end
  end

  // ---------------------------------------------------------------- control
  assign br_inc = br_r + 6'd1;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    br_nxt    = br_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    ev_nxt    = ev_r;
    off_nxt   = off_r;
    bi_nxt    = bi_r;
    out_load  = 1'b0;
    out_d     = '0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    append    = 1'b0;
    replaced  = 1'b0;
    done      = 1'b0;
    oversize  = 1'b0;
    app_idx   = count_r;
    ctl          = '0;
    ctl.key      = in_item.event_type;
    ctl.new_size = in_item.event_size;
    ctl.new_type = in_item.event_type;
    case (state_r)
      cepp_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_item.cmd == cepp_pkg::CMD_GET) begin
            k_nxt     = '0;
            pos_nxt   = 8'd1;
            state_nxt = cepp_pkg::S_CNT;
          end else begin
            if (in_item.event_size != 6'd0) begin
              wr_en  = br_r < MAXS;
              br_nxt = br_inc;
              done   = br_inc >= in_item.event_size;
            end else begin
              done = 1'b1;
            end
            if (done) begin
              br_nxt     = '0;
              oversize   = in_item.event_size > MAXS;
              ctl.remove = in_item.replace_same_type && !oversize;
              replaced   = ctl.remove && hit[NCELL];
              append     = !oversize && (replaced || (count_r < DEPTH));
              app_idx    = count_r - IW'(replaced);
              count_nxt  = count_r - IW'(replaced) + IW'(append);
              out_load   = 1'b1;
              out_d.result_kind = cepp_pkg::KIND_STATUS;
              if (oversize) begin
                out_d.add_status = cepp_pkg::ST_DROP_SIZE;
              end else if (!append) begin
                out_d.add_status = cepp_pkg::ST_DROP_FULL;
              end else if (replaced) begin
                out_d.add_status = cepp_pkg::ST_REPLACED;
              end else begin
                out_d.add_status = cepp_pkg::ST_APPENDED;
              end
            end
          end
        end
      end
      cepp_pkg::S_CNT: begin
        // count how many head entries fit
        if ((k_r < count_r) && ((pos_r + {2'b00, q[k_r].size} + 8'd2) < PB8)) begin
          pos_nxt = pos_r + {2'b00, q[k_r].size} + 8'd2;
          k_nxt   = k_r + IW'(1);
        end else begin
          state_nxt = cepp_pkg::S_EMIT_CNT;
        end
      end
      cepp_pkg::S_EMIT_CNT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = cepp_pkg::KIND_PACKET;
          out_d.packet_byte = 8'(k_r);
          bi_nxt            = BIW'(1);
          ev_nxt            = k_r;
          state_nxt = (k_r != '0) ? cepp_pkg::S_SZ : cepp_pkg::S_ZERO;
        end
      end
      cepp_pkg::S_SZ: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = cepp_pkg::KIND_PACKET;
          out_d.packet_byte = {2'b00, q[0].size};
          bi_nxt            = bi_r + BIW'(1);
          off_nxt           = '0;
          state_nxt         = cepp_pkg::S_TY;
        end
      end
      cepp_pkg::S_TY: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = cepp_pkg::KIND_PACKET;
          out_d.packet_byte = q[0].etype;
          bi_nxt            = bi_r + BIW'(1);
          state_nxt = (q[0].size == 6'd0) ? cepp_pkg::S_POP : cepp_pkg::S_RD;
        end
      end
      cepp_pkg::S_RD: begin
        rd_en     = 1'b1;
        state_nxt = cepp_pkg::S_PAY;
      end
      cepp_pkg::S_PAY: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = cepp_pkg::KIND_PACKET;
          out_d.packet_byte = mem_q_r;
          bi_nxt            = bi_r + BIW'(1);
          off_nxt           = off_r + 6'd1;
          state_nxt = ((off_r + 6'd1) == q[0].size) ? cepp_pkg::S_POP : cepp_pkg::S_RD;
        end
      end
      cepp_pkg::S_POP: begin
        ctl.pop   = 1'b1;
        count_nxt = count_r - IW'(1);
        ev_nxt    = ev_r - IW'(1);
        state_nxt = (ev_r != IW'(1)) ? cepp_pkg::S_SZ : cepp_pkg::S_ZERO;
      end
      cepp_pkg::S_ZERO: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.result_kind = cepp_pkg::KIND_PACKET;
          out_d.last_byte   = (bi_r == LASTI);
          bi_nxt            = bi_r + BIW'(1);
          if (bi_r == LASTI) begin
            state_nxt = cepp_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cepp_pkg::S_IDLE;
      end
    endcase
  end

  assign wr_addr = AW'(q[count_r].buf_id) * MAXA + AW'(br_r);
  assign rd_addr = AW'(q[0].buf_id) * MAXA + AW'(off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cepp_pkg::S_IDLE;
      count_r     <= '0;
      br_r        <= '0;
      k_r         <= '0;
      pos_r       <= '0;
      ev_r        <= '0;
      off_r       <= '0;
      bi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      br_r    <= br_nxt;
      k_r     <= k_nxt;
      pos_r   <= pos_nxt;
      ev_r    <= ev_nxt;
      off_r   <= off_nxt;
      bi_r    <= bi_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_d;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_item.data_byte;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: rtl/cepp_checker.sv
// ----------------------------------------------------------------------------
// cepp_checker
// Port-level checks of the event packet packer.
// ----------------------------------------------------------------------------
module cepp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input cepp_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input cepp_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_get_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_item.cmd == cepp_pkg::CMD_GET) |=> in_stall)
    else $error("item taken while a packet is being built");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.result_kind == cepp_pkg::KIND_STATUS)
    |-> (out_item.packet_byte == 8'd0) && !out_item.last_byte)
    else $error("status item carries packet fields");

  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_byte
    |-> (out_item.packet_byte == 8'd0) && (out_item.add_status == 2'd0))
    else $error("final packet byte not zero");

endmodule

bind coalescing_event_packet_packer_top cepp_checker u_cepp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
